### rtl/cms_pkg.sv
// Shared types and constants for the CoAP message serializer.
`default_nettype none

package cms_pkg;

    localparam int MAX_RESULTS = 5;

    typedef enum logic [2:0] {
        CMD_HEADER        = 3'd0,
        CMD_TOKEN_BYTE    = 3'd1,
        CMD_OPTION_HEAD   = 3'd2,
        CMD_OPTION_BYTE   = 3'd3,
        CMD_PAYLOAD_START = 3'd4,
        CMD_PAYLOAD_BYTE  = 3'd5
    } cmd_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DROPPED  = 2'd1;
    localparam logic [1:0] STATUS_PAST_CAP = 2'd2;

    // Result burst caused by one request: either one dropped-item mark or
    // up to MAX_RESULTS serialized bytes.
    typedef struct packed {
        logic [2:0]                  count;
        logic                        drop;
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      past_cap;
        logic [15:0]                 wc_base;
    } burst_t;

endpackage

`default_nettype wire

### rtl/cms_encoder.sv
// Message state and encoding of one request into a result burst.
`default_nettype none

module cms_encoder
    import cms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  command,
    input  wire logic [1:0]  version,
    input  wire logic [1:0]  msg_type,
    input  wire logic [3:0]  token_length,
    input  wire logic [7:0]  code,
    input  wire logic [15:0] message_id,
    input  wire logic [15:0] buffer_length,
    input  wire logic [15:0] option_number,
    input  wire logic [15:0] option_length,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,
    output burst_t           burst
);

    localparam logic [15:0] EXT_ONE = 16'd13;
    localparam logic [15:0] EXT_TWO = 16'd269;
    localparam logic [3:0]  NIB_ONE = 4'd13;
    localparam logic [3:0]  NIB_TWO = 4'd14;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [15:0] HEADER_BYTES = 16'd4;

    logic [15:0] room_reg, room_next;
    logic [15:0] wc_reg, wc_next;
    logic        tdrop_reg, tdrop_next;
    logic        pdrop_reg, pdrop_next;

    logic [15:0] room_base, wc_base;
    logic [2:0]  n_emit;
    logic        drop;
    logic [MAX_RESULTS-1:0][7:0] bytes;

    logic [3:0]       num_nib, len_nib;
    logic [1:0]       num_cnt, len_cnt;
    logic [1:0][7:0]  num_ext, len_ext;

    function automatic logic [3:0] nibble_of(input logic [15:0] v);
        if (v >= EXT_TWO) begin
            return NIB_TWO;
        end
        if (v >= EXT_ONE) begin
            return NIB_ONE;
        end
        return v[3:0];
    endfunction

    function automatic logic [1:0] ext_count(input logic [15:0] v);
        if (v >= EXT_TWO) begin
            return 2'd2;
        end
        if (v >= EXT_ONE) begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

    // Extended bytes in wire order: entry 0 goes out first.
    function automatic logic [1:0][7:0] ext_bytes(input logic [15:0] v);
        logic [15:0] e;
        logic [1:0][7:0] r;
        if (v >= EXT_TWO) begin
            e = v - EXT_TWO;
            r[0] = e[15:8];
            r[1] = e[7:0];
        end else begin
            e = v - EXT_ONE;
            r[0] = e[7:0];
            r[1] = 8'd0;
        end
        return r;
    endfunction

    always_comb
    begin
        num_nib = nibble_of(option_number);
        len_nib = nibble_of(option_length);
        num_cnt = ext_count(option_number);
        len_cnt = ext_count(option_length);
        num_ext = ext_bytes(option_number);
        len_ext = ext_bytes(option_length);
    end

    always_comb
    begin
        room_base  = room_reg;
        wc_base    = wc_reg;
        n_emit     = 3'd0;
        drop       = 1'b0;
        bytes      = '0;
        tdrop_next = tdrop_reg;
        pdrop_next = pdrop_reg;

        unique case (cmd_t'(command))
            CMD_HEADER:
            begin
                room_base  = buffer_length;
                wc_base    = 16'd0;
                pdrop_next = 1'b0;
                if (buffer_length < HEADER_BYTES) begin
                    drop = 1'b1;
                end else begin
                    n_emit   = 3'd4;
                    bytes[0] = {version, msg_type, token_length};
                    bytes[1] = code;
                    bytes[2] = message_id[15:8];
                    bytes[3] = message_id[7:0];
                end
            end
            CMD_TOKEN_BYTE:
            begin
                if (tdrop_reg) begin
                    drop = 1'b1;
                end else begin
                    n_emit   = 3'd1;
                    bytes[0] = data_byte;
                end
            end
            CMD_OPTION_HEAD:
            begin
                n_emit   = 3'd1 + {1'b0, num_cnt} + {1'b0, len_cnt};
                bytes[0] = {num_nib, len_nib};
                bytes[1] = (num_cnt != 2'd0) ? num_ext[0] : len_ext[0];
                bytes[2] = (num_cnt == 2'd2) ? num_ext[1] :
                           (num_cnt == 2'd1) ? len_ext[0] : len_ext[1];
                bytes[3] = (num_cnt == 2'd2) ? len_ext[0] : len_ext[1];
                bytes[4] = len_ext[1];
            end
            CMD_OPTION_BYTE:
            begin
                n_emit   = 3'd1;
                bytes[0] = data_byte;
            end
            CMD_PAYLOAD_START:
            begin
                if (payload_length >= room_reg) begin
                    drop       = 1'b1;
                    pdrop_next = 1'b1;
                end else if (payload_length == 16'd0) begin
                    pdrop_next = 1'b1;
                end else begin
                    pdrop_next = 1'b0;
                    n_emit     = 3'd1;
                    bytes[0]   = PAYLOAD_MARKER;
                end
            end
            CMD_PAYLOAD_BYTE:
            begin
                if (pdrop_reg) begin
                    drop = 1'b1;
                end else begin
                    n_emit   = 3'd1;
                    bytes[0] = data_byte;
                end
            end
            default:
            begin
            end
        endcase

        // Room saturates at zero once the buffer is full.
        if (room_base >= {13'd0, n_emit}) begin
            room_next = room_base - {13'd0, n_emit};
        end else begin
            room_next = 16'd0;
        end
        wc_next = wc_base + {13'd0, n_emit};

        if (cmd_t'(command) == CMD_HEADER) begin
            tdrop_next = room_next < {12'd0, token_length};
        end
    end

    always_comb
    begin
        burst.count   = drop ? 3'd1 : n_emit;
        burst.drop    = drop;
        burst.bytes   = bytes;
        burst.wc_base = wc_base;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            burst.past_cap[i] = room_base <= 16'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            room_reg  <= 16'd0;
            wc_reg    <= 16'd0;
            tdrop_reg <= 1'b0;
            pdrop_reg <= 1'b0;
        end else if (accept) begin
            room_reg  <= room_next;
            wc_reg    <= wc_next;
            tdrop_reg <= tdrop_next;
            pdrop_reg <= pdrop_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cms_emitter.sv
// Burst and output register: one result per cycle while out_stall is low.
`default_nettype none

module cms_emitter
    import cms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  burst_t           burst_in,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             last_of_run,
    output logic [1:0]       status,
    output logic [15:0]      bytes_written
);

    burst_t      burst_reg;
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [15:0] bw_reg;

    logic out_adv;
    logic at_last;
    logic drain;
    logic load;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign at_last  = idx_reg == (burst_reg.count - 3'd1);
    assign drain    = busy_reg && out_adv && at_last;
    assign in_stall = busy_reg && !drain;
    assign load     = accept && (burst_in.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end else if (busy_reg && out_adv) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            burst_reg <= burst_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && busy_reg) begin
            last_reg <= at_last;
            if (burst_reg.drop) begin
                out_byte_reg   <= 8'd0;
                byte_valid_reg <= 1'b0;
                status_reg     <= STATUS_DROPPED;
                bw_reg         <= burst_reg.wc_base;
            end else begin
                out_byte_reg   <= burst_reg.bytes[idx_reg];
                byte_valid_reg <= 1'b1;
                status_reg     <= burst_reg.past_cap[idx_reg] ? STATUS_PAST_CAP : STATUS_OK;
                bw_reg         <= burst_reg.wc_base + {13'd0, idx_reg} + 16'd1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign last_of_run   = last_reg;
    assign status        = status_reg;
    assign bytes_written = bw_reg;

endmodule

`default_nettype wire

### rtl/coap_message_serializer_core.sv
// Top level of the CoAP message serializer: request port, encoder, emitter.
`default_nettype none

// Serializes a CoAP message (RFC 7252 layout) one output byte per result.
// Each request is encoded in the cycle it is accepted into a burst of up to
// five results, held in a burst register and shifted out through an output
// register, one result per cycle while out_stall is low. Requests that yield
// one result (token, option value, payload byte, payload marker or a
// dropped-item mark) stream back to back while out_stall is low; a header
// (four bytes) or an option head (one to five bytes) holds off the next
// request until the single-byte output register drains the burst register.
// Requests that yield no result (empty payload start, unused commands) are
// not loaded into the burst register. The next request is taken in the cycle
// the last result of the current burst moves to the output register. Status
// 1 marks a dropped request (byte_valid low, out_byte zero); status 2 marks
// a byte written with the buffer already full. bytes_written counts bytes
// of the current message and wraps at 16 bits.
module coap_message_serializer_core
    import cms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [1:0]  version,
    input  wire logic [1:0]  msg_type,
    input  wire logic [3:0]  token_length,
    input  wire logic [7:0]  code,
    input  wire logic [15:0] message_id,
    input  wire logic [15:0] buffer_length,
    input  wire logic [15:0] option_number,
    input  wire logic [15:0] option_length,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             last_of_run,
    output logic [1:0]       status,
    output logic [15:0]      bytes_written
);

    logic   accept;
    burst_t burst;

    // Take a request whenever the burst register is free or frees this cycle.
    assign accept = in_valid && !in_stall;

    cms_encoder u_encoder (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (command),
        .version        (version),
        .msg_type       (msg_type),
        .token_length   (token_length),
        .code           (code),
        .message_id     (message_id),
        .buffer_length  (buffer_length),
        .option_number  (option_number),
        .option_length  (option_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .burst          (burst)
    );

    cms_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .burst_in      (burst),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run),
        .status        (status),
        .bytes_written (bytes_written)
    );

    // A dropped-item mark is always a single, final result with status 1.
    a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> status == STATUS_DROPPED && last_of_run && out_byte == 8'd0)
        else $error("dropped-item result malformed");

    // A written byte never carries the dropped status.
    a_written_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status != STATUS_DROPPED)
        else $error("written byte carries dropped status");

    // Within a burst, the next byte follows at once and counts up by one.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=>
            out_valid && byte_valid && bytes_written == $past(bytes_written) + 16'd1)
        else $error("burst broke off or count skipped");

endmodule

`default_nettype wire

### tb/coap_serializer_checker.sv
// Checker for the CoAP serializer: predicts the byte stream and compares every result.
module coap_serializer_checker
    import cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  version,
    input  logic [1:0]  msg_type,
    input  logic [3:0]  token_length,
    input  logic [7:0]  code,
    input  logic [15:0] message_id,
    input  logic [15:0] buffer_length,
    input  logic [15:0] option_number,
    input  logic [15:0] option_length,
    input  logic [15:0] payload_length,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        last_of_run,
    input  logic [1:0]  status,
    input  logic [15:0] bytes_written,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          REPORT_LIMIT     = 10;
    localparam logic [15:0] EXT_BYTE_MIN     = 16'd13;
    localparam logic [15:0] EXT_WORD_MIN     = 16'd269;
    localparam logic [3:0]  NIBBLE_EXT_BYTE  = 4'd13;
    localparam logic [3:0]  NIBBLE_EXT_WORD  = 4'd14;
    localparam logic [7:0]  PAYLOAD_MARKER   = 8'hFF;
    localparam int          HEADER_BYTES     = 4;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic [1:0]  status;
        logic [15:0] bytes_written;
    } serial_byte_t;

    serial_byte_t expected_bytes[$];
    serial_byte_t burst[$];

    logic [15:0] room_left;
    logic [15:0] written_count;
    logic        token_dropping;
    logic        payload_dropping;

    // Write one byte; a full buffer keeps room at zero and flags the byte.
    task automatic write_byte(input logic [7:0] value);
        logic [1:0] st;
        st = STATUS_OK;
        if (room_left == 16'd0)
            st = STATUS_PAST_CAP;
        else
            room_left = room_left - 16'd1;
        written_count = written_count + 16'd1;
        burst.push_back('{value, 1'b1, 1'b0, st, written_count});
    endtask

    task automatic drop_request();
        burst.push_back('{8'h00, 1'b0, 1'b0, STATUS_DROPPED, written_count});
    endtask

    function automatic logic [3:0] option_nibble(input logic [15:0] value);
        if (value >= EXT_WORD_MIN)
            return NIBBLE_EXT_WORD;
        if (value >= EXT_BYTE_MIN)
            return NIBBLE_EXT_BYTE;
        return value[3:0];
    endfunction

    task automatic write_extension(input logic [15:0] value);
        logic [15:0] ext;
        ext = value - EXT_WORD_MIN;
        if (value >= EXT_WORD_MIN)
        begin
            write_byte(ext[15:8]);
            write_byte(ext[7:0]);
        end
        else if (value >= EXT_BYTE_MIN)
        begin
            ext = value - EXT_BYTE_MIN;
            write_byte(ext[7:0]);
        end
    endtask

    // Encode the accepted request and queue the bytes it must produce.
    task automatic encode_request();
        burst.delete();
        case (command)
            CMD_HEADER:
            begin
                written_count    = 16'd0;
                payload_dropping = 1'b0;
                room_left        = buffer_length;
                if (buffer_length < HEADER_BYTES)
                    drop_request();
                else
                begin
                    write_byte({version, msg_type, token_length});
                    write_byte(code);
                    write_byte(message_id[15:8]);
                    write_byte(message_id[7:0]);
                end
                token_dropping = room_left < {12'd0, token_length};
            end
            CMD_TOKEN_BYTE:
            begin
                if (token_dropping)
                    drop_request();
                else
                    write_byte(data_byte);
            end
            CMD_OPTION_HEAD:
            begin
                write_byte({option_nibble(option_number), option_nibble(option_length)});
                write_extension(option_number);
                write_extension(option_length);
            end
            CMD_OPTION_BYTE:
                write_byte(data_byte);
            CMD_PAYLOAD_START:
            begin
                if ({1'b0, payload_length} + 17'd1 > {1'b0, room_left})
                begin
                    payload_dropping = 1'b1;
                    drop_request();
                end
                else if (payload_length == 16'd0)
                    payload_dropping = 1'b1;
                else
                begin
                    payload_dropping = 1'b0;
                    write_byte(PAYLOAD_MARKER);
                end
            end
            CMD_PAYLOAD_BYTE:
            begin
                if (payload_dropping)
                    drop_request();
                else
                    write_byte(data_byte);
            end
            default:
                ;
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last_of_run = 1'b1;
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        serial_byte_t seen;
        serial_byte_t want;
        if (!rst_n)
        begin
            room_left        = 16'd0;
            written_count    = 16'd0;
            token_dropping   = 1'b0;
            payload_dropping = 1'b0;
            expected_bytes.delete();
            fail_count       = 0;
            pending_count    = 0;
            results_checked  = 0;
        end
        else
        begin
            // Compare first: a result never belongs to a request taken at this edge.
            if (out_valid && !out_stall)
            begin
                seen = '{out_byte, byte_valid, last_of_run, status, bytes_written};
                results_checked++;
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result byte=%02h valid=%0b last=%0b st=%0d cnt=%0d",
                                 $realtime, seen.out_byte, seen.byte_valid, seen.last_of_run,
                                 seen.status, seen.bytes_written);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected byte=%02h valid=%0b last=%0b st=%0d ",
                                      "cnt=%0d, got byte=%02h valid=%0b last=%0b st=%0d cnt=%0d"},
                                     $realtime, want.out_byte, want.byte_valid, want.last_of_run,
                                     want.status, want.bytes_written, seen.out_byte,
                                     seen.byte_valid, seen.last_of_run, seen.status,
                                     seen.bytes_written);
                    end
                end
            end
            if (in_valid && !in_stall)
                encode_request();
            pending_count = expected_bytes.size();
        end
    end

endmodule

### tb/tb_top.sv
// Top of the CoAP serializer testbench: clock, reset, request traffic and verdict.
module tb_top
    import cms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RESET_CYCLES    = 12;
    localparam int         PHASE_REQUESTS  = 65;
    localparam int         HOLD_OFF_CYCLES = 250;
    localparam int         HOLD_OFF_DELAY  = 40;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         WATCHDOG_LIMIT  = 2000;
    // Command codes the block must ignore.
    localparam logic [2:0] CMD_SPARE_A     = 3'd6;
    localparam logic [2:0] CMD_SPARE_B     = 3'd7;

    typedef struct {
        logic [2:0]  command;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [15:0] buffer_length;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [15:0] buffer_length;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic [1:0]  status;
    logic [15:0] bytes_written;

    int fail_count;
    int pending_count;
    int results_checked;

    // Traffic shaping knobs, percent of cycles.
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_off;
    int   requests_sent;

    always #5 clk = ~clk;

    coap_message_serializer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .version        (version),
        .msg_type       (msg_type),
        .token_length   (token_length),
        .code           (code),
        .message_id     (message_id),
        .buffer_length  (buffer_length),
        .option_number  (option_number),
        .option_length  (option_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .status         (status),
        .bytes_written  (bytes_written)
    );

    coap_serializer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .version         (version),
        .msg_type        (msg_type),
        .token_length    (token_length),
        .code            (code),
        .message_id      (message_id),
        .buffer_length   (buffer_length),
        .option_number   (option_number),
        .option_length   (option_length),
        .payload_length  (payload_length),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .last_of_run     (last_of_run),
        .status          (status),
        .bytes_written   (bytes_written),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    // Receiver: stall at the phase's rate, or hold off completely while
    // the pressure stretch is running.
    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);

    // Fill every field at random so that unused fields toggle too;
    // callers then pin the fields that matter for the command.
    function automatic request_t random_request(input logic [2:0] cmd);
        request_t r;
        r.command        = cmd;
        r.version        = 2'($urandom);
        r.msg_type       = 2'($urandom);
        r.token_length   = 4'($urandom);
        r.code           = 8'($urandom);
        r.message_id     = 16'($urandom);
        r.buffer_length  = 16'($urandom);
        r.option_number  = 16'($urandom);
        r.option_length  = 16'($urandom);
        r.payload_length = 16'($urandom);
        r.data_byte      = 8'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until it is accepted. Entered and left at a
    // falling edge with in_valid still high, so back-to-back requests never drop
    // valid in between.
    task automatic offer(input request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command        <= r.command;
        version        <= r.version;
        msg_type       <= r.msg_type;
        token_length   <= r.token_length;
        code           <= r.code;
        message_id     <= r.message_id;
        buffer_length  <= r.buffer_length;
        option_number  <= r.option_number;
        option_length  <= r.option_length;
        payload_length <= r.payload_length;
        data_byte      <= r.data_byte;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (r.command <= CMD_PAYLOAD_BYTE)
            requests_sent++;
    endtask

    // One message in mostly well-formed order: header, token, options, payload.
    // Small buffers dominate so that room runs out often; now and then the
    // counts are broken on purpose.
    task automatic send_message();
        request_t r;
        int       token_count;
        int       value_count;
        r = random_request(CMD_HEADER);
        case ($urandom_range(0, 9))
            0:       r.buffer_length = 16'($urandom);
            1:       r.buffer_length = 16'($urandom_range(0, 3));
            default: r.buffer_length = 16'($urandom_range(4, 40));
        endcase
        offer(r);
        token_count = r.token_length;
        if ($urandom_range(0, 7) == 0)
            token_count = $urandom_range(0, 15);
        repeat (token_count)
            offer(random_request(CMD_TOKEN_BYTE));
        repeat ($urandom_range(0, 3))
        begin
            r = random_request(CMD_OPTION_HEAD);
            case ($urandom_range(0, 3))
                0: r.option_number = 16'($urandom_range(0, 12));
                1: r.option_number = 16'($urandom_range(13, 268));
                2: r.option_number = 16'($urandom_range(269, 65535));
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0, 1, 2: r.option_length = 16'($urandom_range(0, 6));
                3:       r.option_length = 16'($urandom_range(13, 20));
                4:       r.option_length = 16'($urandom_range(269, 300));
                default: ;
            endcase
            value_count = (r.option_length <= 20) ? r.option_length : $urandom_range(0, 3);
            offer(r);
            repeat (value_count)
                offer(random_request(CMD_OPTION_BYTE));
        end
        if ($urandom_range(0, 4) != 0)
        begin
            r = random_request(CMD_PAYLOAD_START);
            case ($urandom_range(0, 7))
                0:       r.payload_length = 16'd0;
                1:       ;
                default: r.payload_length = 16'($urandom_range(1, 10));
            endcase
            value_count = (r.payload_length <= 10) ? r.payload_length : $urandom_range(0, 3);
            value_count += $urandom_range(0, 1);
            offer(r);
            repeat (value_count)
                offer(random_request(CMD_PAYLOAD_BYTE));
        end
    endtask

    // Watchdog: end the run when neither channel moves for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired, %0d results outstanding", $realtime, pending_count);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        request_t r;
        int       phase_goal;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_HEADER;
        version        = '0;
        msg_type       = '0;
        token_length   = '0;
        code           = '0;
        message_id     = '0;
        buffer_length  = '0;
        option_number  = '0;
        option_length  = '0;
        payload_length = '0;
        data_byte      = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Option value byte before any header: no room, so it
        // is written past capacity.
        offer(random_request(CMD_OPTION_BYTE));
        // Header that does not fit, with a long token: drop it and the token.
        r = random_request(CMD_HEADER);
        r.buffer_length = 16'd0;
        r.token_length  = 4'd15;
        offer(r);
        offer(random_request(CMD_TOKEN_BYTE));
        // Header one byte short of fitting, empty token.
        r = random_request(CMD_HEADER);
        r.buffer_length = 16'd3;
        r.token_length  = 4'd0;
        offer(r);
        // Largest header: all fields at their top values.
        r = random_request(CMD_HEADER);
        r.buffer_length = 16'hFFFF;
        r.version       = 2'd3;
        r.msg_type      = 2'd3;
        r.token_length  = 4'd15;
        r.code          = 8'hFF;
        r.message_id    = 16'hFFFF;
        offer(r);
        r = random_request(CMD_TOKEN_BYTE);
        r.data_byte = 8'hFF;
        offer(r);
        // Option heads across the nibble, one-byte and two-byte extension bands.
        r = random_request(CMD_OPTION_HEAD);
        r.option_number = 16'd0;
        r.option_length = 16'd0;
        offer(r);
        r = random_request(CMD_OPTION_HEAD);
        r.option_number = 16'd12;
        r.option_length = 16'd12;
        offer(r);
        r = random_request(CMD_OPTION_HEAD);
        r.option_number = 16'd13;
        r.option_length = 16'd268;
        offer(r);
        r = random_request(CMD_OPTION_HEAD);
        r.option_number = 16'd269;
        r.option_length = 16'hFFFF;
        offer(r);
        r = random_request(CMD_OPTION_HEAD);
        r.option_number = 16'hFFFF;
        r.option_length = 16'd269;
        offer(r);
        r = random_request(CMD_OPTION_BYTE);
        r.data_byte = 8'h00;
        offer(r);
        // Empty payload: no marker, and the payload byte after it is dropped.
        r = random_request(CMD_PAYLOAD_START);
        r.payload_length = 16'd0;
        offer(r);
        offer(random_request(CMD_PAYLOAD_BYTE));
        // Payload too large for the remaining room.
        r = random_request(CMD_PAYLOAD_START);
        r.payload_length = 16'hFFFF;
        offer(r);
        r = random_request(CMD_PAYLOAD_START);
        r.payload_length = 16'd2;
        offer(r);
        r = random_request(CMD_PAYLOAD_BYTE);
        r.data_byte = 8'h00;
        offer(r);
        // Unused commands: ignored.
        offer(random_request(CMD_SPARE_A));
        offer(random_request(CMD_SPARE_B));
        // Header that fills the buffer exactly: token dropped, option byte past capacity.
        r = random_request(CMD_HEADER);
        r.buffer_length = 16'd4;
        r.token_length  = 4'd1;
        r.version       = 2'd0;
        r.msg_type      = 2'd0;
        r.code          = 8'h00;
        r.message_id    = 16'h0000;
        offer(r);
        offer(random_request(CMD_TOKEN_BYTE));
        offer(random_request(CMD_OPTION_BYTE));
        // Payload that fits exactly: marker plus one byte use the last two slots.
        r = random_request(CMD_HEADER);
        r.buffer_length = 16'd6;
        r.token_length  = 4'd0;
        offer(r);
        r = random_request(CMD_PAYLOAD_START);
        r.payload_length = 16'd1;
        offer(r);
        offer(random_request(CMD_PAYLOAD_BYTE));

        // Random part in four phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            // Drop valid, then change the knobs away from the falling edge.
            in_valid <= 1'b0;
            @(posedge clk);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            @(negedge clk);
            phase_goal = requests_sent + PHASE_REQUESTS;
            fork
                while (requests_sent < phase_goal)
                begin
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 4))
                            offer(random_request(3'($urandom_range(0, 7))));
                    else
                        send_message();
                end
                // Pressure: hold the receiver off while the sender keeps offering,
                // so the block fills up and stalls its input.
                if (phase == 0)
                begin
                    repeat (HOLD_OFF_DELAY) @(posedge clk);
                    hold_off = 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off = 1'b0;
                end
            join
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected byte, then watch for strays.
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Summary: %0d requests over four traffic phases and a %0d-cycle receiver hold-off,",
                 requests_sent, HOLD_OFF_CYCLES);
        $display("Summary: %0d result bytes compared, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### coap_message_serializer_core.f
rtl/cms_pkg.sv
rtl/cms_encoder.sv
rtl/cms_emitter.sv
rtl/coap_message_serializer_core.sv
tb/coap_serializer_checker.sv
tb/tb_top.sv
